/* hw/rtl/rss_pkg.sv */
// shared types, codes and key helpers for the record sort and search block
package rss_pkg;

	localparam int CAPACITY_DEF  = 8;
	localparam int KEY_CHARS_DEF = 8;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_SORT   = 2'd1;
	localparam logic [1:0] ACT_SEARCH = 2'd2;

	localparam logic KIND_REC = 1'b0;
	localparam logic KIND_ANS = 1'b1;

	localparam logic signed [3:0] NO_MATCH = -4'sd1;

	typedef struct packed {
		logic [63:0] key;
		logic [13:0] year;
		logic [63:0] color_high;
		logic [63:0] color_low;
		logic [31:0] price;
	} rec_t;

	typedef struct packed {
		logic gt;
		logic eq;
	} cmp_res_t;

	// keep the leading characters up to the first nul and at most nchars of them, zero the rest
	function automatic logic [63:0] clean_key(input logic [63:0] k, input int nchars);
		logic [63:0] r;
		logic alive;
		logic [7:0] ch;
		r = '0;
		alive = 1'b1;
		for (int b = 0; b < 8; b++) begin
			ch = k[63 - 8 * b -: 8];
			if (b >= nchars || ch == 8'h00) begin
				alive = 1'b0;
			end
			if (alive) begin
				r[63 - 8 * b -: 8] = ch;
			end
		end
		return r;
	endfunction

endpackage

/* hw/rtl/rss_ram.sv */
// generic single write port ram with registered read
module rss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/rss_key_cmp.sv */
// shared key comparator: cleans both keys and gives greater-than and equal
module rss_key_cmp #(
	parameter int KEY_CHARS = 8
) (
	input  logic [63:0]        key_a,
	input  logic [63:0]        key_b,
	output rss_pkg::cmp_res_t  res
);
	import rss_pkg::*;

	logic [63:0] ca;
	logic [63:0] cb;

	always_comb begin
		ca = clean_key(key_a, KEY_CHARS);
		cb = clean_key(key_b, KEY_CHARS);
		res.gt = (ca > cb);
		res.eq = (ca == cb);
	end

endmodule

/* hw/rtl/record_sort_and_search_top.sv */
// top level of the record sort and search block: sequencer, record store and result register
// A load beat appends a record while fewer than CAPACITY are held.
// With n records stored, a sort runs n-1 bubble passes over the
// single-read-port record ram, every step going through the one shared key comparator,
// then emits the n records one by one, waiting while a previous result beat is still held;
// a search reads and compares each stored record in turn, then loads its answer beat.
// The block takes no new beat while a sort or search is in progress.
module record_sort_and_search_top #(
	parameter int CAPACITY  = rss_pkg::CAPACITY_DEF,
	parameter int KEY_CHARS = rss_pkg::KEY_CHARS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         action,
	input  logic [63:0]        plate_key,
	input  logic [13:0]        year,
	input  logic [63:0]        color_high,
	input  logic [63:0]        color_low,
	input  logic [31:0]        price_bits,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               kind,
	output logic [63:0]        plate_out,
	output logic [13:0]        year_out,
	output logic [63:0]        color_high_out,
	output logic [63:0]        color_low_out,
	output logic [31:0]        price_out,
	output logic signed [3:0]  match_index,
	output logic               last
);
	import rss_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD0  = 4'd1;
	localparam logic [3:0] ST_LD0  = 4'd2;
	localparam logic [3:0] ST_RD   = 4'd3;
	localparam logic [3:0] ST_CMP  = 4'd4;
	localparam logic [3:0] ST_END  = 4'd5;
	localparam logic [3:0] ST_ERD  = 4'd6;
	localparam logic [3:0] ST_ELD  = 4'd7;
	localparam logic [3:0] ST_QRD  = 4'd8;
	localparam logic [3:0] ST_QCMP = 4'd9;
	localparam logic [3:0] ST_QOUT = 4'd10;

	logic [3:0]      state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   pass_q;
	logic [CW-1:0]   j_q;
	logic [3:0]      pos_q;
	logic [63:0]     key_q;
	rec_t            carry_q;

	logic            accept;
	logic            full;
	logic            j_last;
	logic [CW-1:0]   j_inc;
	logic [CW-1:0]   j_dec;
	logic [CW-1:0]   cnt_dec;

	logic            we;
	logic [AW-1:0]   waddr;
	rec_t            wdata;
	logic [AW-1:0]   raddr;
	rec_t            rdata;
	rec_t            in_rec;

	logic [63:0]     cmp_a;
	cmp_res_t        cmp;

	logic            rsp_load;
	logic            rsp_valid_q;

	assign accept  = req_valid && !req_stall;
	assign full    = (count_q == CW'(CAPACITY));
	assign j_inc   = j_q + CW'(1);
	assign j_dec   = j_q - CW'(1);
	assign cnt_dec = count_q - CW'(1);
	assign j_last  = (j_inc == count_q);

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	assign in_rec.key        = plate_key;
	assign in_rec.year       = year;
	assign in_rec.color_high = color_high;
	assign in_rec.color_low  = color_low;
	assign in_rec.price      = price_bits;

	// sort compares the carried record against the one just read; search uses the held key
	assign cmp_a = (state_q == ST_QCMP) ? key_q : carry_q.key;

	rss_key_cmp #(
		.KEY_CHARS(KEY_CHARS)
	) u_cmp (
		.key_a(cmp_a),
		.key_b(rdata.key),
		.res  (cmp)
	);

	rss_ram #(
		.WIDTH($bits(rec_t)),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = in_rec;
		raddr = j_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				we = accept && (action == ACT_LOAD) && !full;
			end
			ST_RD0: begin
				raddr = '0;
			end
			ST_CMP: begin
				we    = 1'b1;
				waddr = j_dec[AW-1:0];
				wdata = cmp.gt ? rdata : carry_q;
			end
			ST_END: begin
				we    = 1'b1;
				waddr = cnt_dec[AW-1:0];
				wdata = carry_q;
			end
			default: begin
			end
		endcase
	end

	assign rsp_load = (state_q == ST_ELD) || (state_q == ST_QOUT && !rsp_valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pass_q      <= '0;
			j_q         <= '0;
			pos_q       <= NO_MATCH;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						j_q <= '0;
						case (action)
							ACT_LOAD: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							ACT_SORT: begin
								pass_q <= CW'(1);
								if (count_q == CW'(1)) begin
									state_q <= ST_ERD;
								end else if (count_q != '0) begin
									state_q <= ST_RD0;
								end
							end
							ACT_SEARCH: begin
								pos_q   <= NO_MATCH;
								state_q <= (count_q == '0) ? ST_QOUT : ST_QRD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD0: begin
					state_q <= ST_LD0;
				end
				ST_LD0: begin
					j_q     <= CW'(1);
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (j_last) begin
						state_q <= ST_END;
					end else begin
						j_q     <= j_inc;
						state_q <= ST_RD;
					end
				end
				ST_END: begin
					if (pass_q + CW'(1) == count_q) begin
						j_q     <= '0;
						state_q <= ST_ERD;
					end else begin
						pass_q  <= pass_q + CW'(1);
						state_q <= ST_RD0;
					end
				end
				ST_ERD: begin
					if (!rsp_valid_q) begin
						state_q <= ST_ELD;
					end
				end
				ST_ELD: begin
					if (j_last) begin
						state_q <= ST_IDLE;
					end else begin
						j_q     <= j_inc;
						state_q <= ST_ERD;
					end
				end
				ST_QRD: begin
					state_q <= ST_QCMP;
				end
				ST_QCMP: begin
					if (cmp.eq) begin
						pos_q <= 4'(j_q);
					end
					if (j_last) begin
						state_q <= ST_QOUT;
					end else begin
						j_q     <= j_inc;
						state_q <= ST_QRD;
					end
				end
				ST_QOUT: begin
					if (!rsp_valid_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers: the record carried through a pass, the search key, the result beat
	always_ff @(posedge clk) begin
		if (state_q == ST_LD0 || (state_q == ST_CMP && !cmp.gt)) begin
			carry_q <= rdata;
		end
		if (accept) begin
			key_q <= plate_key;
		end
		if (state_q == ST_ELD) begin
			kind           <= KIND_REC;
			plate_out      <= rdata.key;
			year_out       <= rdata.year;
			color_high_out <= rdata.color_high;
			color_low_out  <= rdata.color_low;
			price_out      <= rdata.price;
			match_index    <= 4'sd0;
			last           <= j_last;
		end else if (rsp_load) begin
			kind           <= KIND_ANS;
			plate_out      <= '0;
			year_out       <= '0;
			color_high_out <= '0;
			color_low_out  <= '0;
			price_out      <= '0;
			match_index    <= $signed(pos_q);
			last           <= 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("record count beyond capacity");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == ACT_LOAD && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("load beat did not advance the record count");

	a_answer_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == KIND_ANS |-> last)
		else $error("search answer without last");

endmodule
